// File: rtl/tolerant_binary_position_search_defines.svh
// Assertion macros shared by the tolerant binary position search RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TOLERANT_BINARY_POSITION_SEARCH_DEFINES_SVH
`define TOLERANT_BINARY_POSITION_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TBPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tbps_pkg.sv
// Shared constants, types and the tolerance compare for the position search.
// Depends on nothing; imported by every module of the block.
package tbps_pkg;

   localparam int unsigned TBPS_TABLE_DEPTH = 1024;

   localparam int unsigned POS_W      = 16;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned CNT_CFG_W  = 11;
   localparam int unsigned TOL_W      = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CNT_CFG_W-1:0] ENTRY_COUNT_RESET = '0;
   localparam logic [TOL_W-1:0]     TOLERANCE_RESET   = 16'd256;

   // Item action codes
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // Register select, taken from paddr bit 2
   localparam logic REG_ENTRY_COUNT = 1'b0;
   localparam logic REG_TOLERANCE   = 1'b1;

   typedef struct packed {
      logic [CNT_CFG_W-1:0] entry_count;
      logic [TOL_W-1:0]     tolerance;
   } cfg_type;

   // True when |pos - key| * 256 <= tol (tol is Q8.8)
   function automatic logic pos_within(logic signed [POS_W-1:0] pos,
                                       logic signed [POS_W-1:0] key,
                                       logic [TOL_W-1:0] tol);
      logic [POS_W:0] diff;
      logic [POS_W:0] mag;
      diff = {pos[POS_W-1], pos} - {key[POS_W-1], key};
      mag  = diff[POS_W] ? (~diff + 1'b1) : diff;
      return {mag, 8'b0} <= {9'b0, tol};
   endfunction

endpackage

// File: rtl/tbps_table.sv
// Position table: one write port, one read port, registered read data.
// Depends on tbps_pkg.
module tbps_table
   import tbps_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TBPS_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
   input  logic [POS_W-1:0]                 wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
   output logic [POS_W-1:0]                 rd_data
);

   logic [POS_W-1:0] mem_ff [TABLE_DEPTH];
   logic [POS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tbps_csr.sv
// Configuration registers behind an APB-style port: entry count and tolerance.
// Depends on tbps_pkg.
module tbps_csr
   import tbps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [CNT_CFG_W-1:0] entry_count_ff;
   logic [TOL_W-1:0]     tolerance_ff;
   logic                 wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
         tolerance_ff   <= TOLERANCE_RESET;
      end else if (wr_strobe) begin
         case (paddr[2])
            REG_ENTRY_COUNT: entry_count_ff <= pwdata[CNT_CFG_W-1:0];
            REG_TOLERANCE:   tolerance_ff   <= pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ENTRY_COUNT: prdata = CSR_DATA_W'(entry_count_ff);
         REG_TOLERANCE:   prdata = CSR_DATA_W'(tolerance_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.entry_count = entry_count_ff;
   assign cfg.tolerance   = tolerance_ff;

endmodule

// File: rtl/tbps_seq.sv
// Search sequencer: item intake, clamp check, bisection over the table, result register.
// Depends on tbps_pkg, the assertion macros and the table's registered read.
`include "tolerant_binary_position_search_defines.svh"
module tbps_seq
   import tbps_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TBPS_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [IDX_W-1:0]                 req_entry_index,
   input  logic signed [POS_W-1:0]          req_entry_position,
   input  logic signed [POS_W-1:0]          req_search_key,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [IDX_W-1:0]                 rsp_match_index,
   output logic signed [POS_W-1:0]          rsp_match_position,
   output logic                             tbl_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]   tbl_wr_addr,
   output logic [POS_W-1:0]                 tbl_wr_data,
   output logic [$clog2(TABLE_DEPTH)-1:0]   tbl_rd_addr,
   input  logic signed [POS_W-1:0]          tbl_rd_data
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PROD_W = TOL_W + CNT_W;
   localparam int unsigned KEY_W  = POS_W + 7;
   localparam int unsigned CMP_W  = (PROD_W > KEY_W) ? PROD_W : KEY_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_CLAMP,
      S_HIT,
      S_PROBE,
      S_LAST,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic signed [POS_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic [CNT_W-1:0]         right_ff, right_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic                     res_found_ff, res_found_in;
   logic [IDX_W-1:0]         res_index_ff, res_index_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;

   logic                     accept;
   logic                     rsp_load;
   logic                     hit_now;
   logic                     go_left;
   logic [CNT_W-1:0]         mid_ext;
   logic [CNT_W-1:0]         count_m1;
   logic [CNT_W-1:0]         new_left;
   logic [CNT_W-1:0]         new_right;
   logic [CNT_W:0]           bound_sum;
   logic [ADDR_W-1:0]        new_mid;
   logic [CMP_W-1:0]         key_scaled;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Table writes go straight through at the transfer edge
   assign tbl_wr_en   = accept && (req_action == ACT_WRITE)
                        && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign tbl_wr_addr = ADDR_W'(req_entry_index);
   assign tbl_wr_data = req_entry_position;

   // Probe datapath on the registered table read
   assign hit_now    = pos_within(tbl_rd_data, key_ff, cfg.tolerance);
   assign go_left    = (tbl_rd_data > key_ff);
   assign mid_ext    = CNT_W'(mid_ff);
   assign count_m1   = count_ff - CNT_W'(1);
   assign new_left   = go_left ? left_ff : mid_ext;
   assign new_right  = go_left ? mid_ext : right_ff;
   assign bound_sum  = (CNT_W + 1)'(new_left) + (CNT_W + 1)'(new_right);
   assign new_mid    = ADDR_W'(bound_sum >> 1);
   assign key_scaled = CMP_W'({key_ff[POS_W-2:0], 8'b0});

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      res_pos_in   = res_pos_ff;
      tbl_rd_addr  = mid_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in   = rsp_pos_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in       = req_search_key;
               count_in     = (32'(cfg.entry_count) > 32'(TABLE_DEPTH))
                              ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg.entry_count);
               res_found_in = 1'b0;
               res_index_in = '0;
               res_pos_in   = '0;
               state_in     = (req_action == ACT_SEARCH) ? S_PREP : S_DONE;
            end
         end
         S_PREP: begin
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else if (key_ff[POS_W-1] || (key_ff == '0)) begin
               mid_in      = '0;
               tbl_rd_addr = '0;
               state_in    = S_HIT;
            end else begin
               prod_in  = PROD_W'(cfg.tolerance) * PROD_W'(count_m1);
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (key_scaled >= CMP_W'(prod_ff)) begin
               mid_in      = ADDR_W'(count_m1);
               tbl_rd_addr = ADDR_W'(count_m1);
               state_in    = S_HIT;
            end else begin
               left_in     = '0;
               right_in    = count_ff;
               mid_in      = ADDR_W'(count_ff >> 1);
               tbl_rd_addr = ADDR_W'(count_ff >> 1);
               state_in    = S_PROBE;
            end
         end
         S_HIT: begin
            res_found_in = 1'b1;
            res_index_in = IDX_W'(mid_ff);
            res_pos_in   = tbl_rd_data;
            state_in     = S_DONE;
         end
         S_PROBE: begin
            if (hit_now) begin
               res_found_in = 1'b1;
               res_index_in = IDX_W'(mid_ff);
               res_pos_in   = tbl_rd_data;
               state_in     = S_DONE;
            end else if ((new_left == left_ff) && (new_right == right_ff)) begin
               state_in = S_DONE;
            end else begin
               left_in     = new_left;
               right_in    = new_right;
               mid_in      = new_mid;
               tbl_rd_addr = new_mid;
               state_in    = (new_left < new_right) ? S_PROBE : S_LAST;
            end
         end
         S_LAST: begin
            if (hit_now) begin
               res_found_in = 1'b1;
               res_index_in = IDX_W'(mid_ff);
               res_pos_in   = tbl_rd_data;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_index_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      count_ff     <= count_in;
      prod_ff      <= prod_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      mid_ff       <= mid_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_match_index    = rsp_index_ff;
   assign rsp_match_position = rsp_pos_ff;

   `TBPS_ASSERT_IMP(a_probe_in_interval, clock, reset, state_ff == S_PROBE,
      (mid_ext >= left_ff) && (mid_ext < right_ff), "probe index outside interval")
   `TBPS_ASSERT_IMP(a_last_closed, clock, reset, state_ff == S_LAST,
      left_ff == right_ff, "final check entered with open interval")
   `TBPS_ASSERT_IMP(a_hit_below_count, clock, reset, state_ff == S_HIT,
      mid_ext < count_ff, "clamp hit beyond entries in use")
   `TBPS_ASSERT_NXT(a_load_returns_idle, clock, reset, rsp_load,
      (state_ff == S_IDLE) && rsp_valid_ff, "result load did not return to idle")

endmodule

// File: rtl/tolerant_binary_position_search.sv
// Tolerant binary position search: sorted position table with tolerance lookup.
// Items are handled one at a time: a new item is taken only after the last result is loaded.
// Reset clears the sequencer, the result valid flag, entry_count to 0 and tolerance to 1.0;
// the table itself is not cleared and holds no valid bits, so no clearing pass follows reset.
module tolerant_binary_position_search
   import tbps_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TBPS_TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   // Item channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic [IDX_W-1:0]         req_entry_index,
   input  logic signed [POS_W-1:0]  req_entry_position,
   input  logic signed [POS_W-1:0]  req_search_key,
   // Result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [IDX_W-1:0]         rsp_match_index,
   output logic signed [POS_W-1:0]  rsp_match_position,
   // Configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

   cfg_type           cfg;
   logic              tbl_wr_en;
   logic [ADDR_W-1:0] tbl_wr_addr;
   logic [POS_W-1:0]  tbl_wr_data;
   logic [ADDR_W-1:0] tbl_rd_addr;
   logic [POS_W-1:0]  tbl_rd_data;

   // Registers: entry_count at byte 0, tolerance (Q8.8) at byte 4.
   // Both are read by the sequencer only while it works on an item; the user
   // must change them only while the block is idle, as the block does not enforce it.
   tbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: takes one item at a time. A write lands in the table at
   // the transfer edge and returns an all-zero result. A search checks the
   // empty table and the two clamp cases, then bisects with one table read
   // per probe until a probed entry lies within tolerance, the interval
   // closes, or a step leaves the interval unchanged. The result register
   // frees the sequencer to take the next transfer while a result waits.
   tbps_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_entry_position (req_entry_position),
      .req_search_key     (req_search_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_position (rsp_match_position),
      .tbl_wr_en          (tbl_wr_en),
      .tbl_wr_addr        (tbl_wr_addr),
      .tbl_wr_data        (tbl_wr_data),
      .tbl_rd_addr        (tbl_rd_addr),
      .tbl_rd_data        (tbl_rd_data)
   );

   // Table: one write and one read port, read data registered. Writes and
   // reads never overlap on one item, and a write finishes before the next
   // item can read, so no forwarding is needed.
   tbps_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

endmodule

// File: bench/testbench.sv
// Self-checking bench for tolerant_binary_position_search: table writes, tolerance lookups
// and register settings, each result predicted and compared. Depends on tbps_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import tbps_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned STEP_CAP     = 64;
   localparam int unsigned PHASE_ITEMS  = 40;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned RAMP_ENTRIES = 256;

   // One lookup answer as the result channel carries it
   typedef struct packed {
      logic                    found;
      logic [IDX_W-1:0]        match_index;
      logic signed [POS_W-1:0] match_position;
   } lookup_type;

   // Mirrors the table and registers; predicts each lookup and checks answers in order
   class lookup_scoreboard;
      logic signed [POS_W-1:0] stored_pos [TBPS_TABLE_DEPTH];
      int unsigned             entry_count;
      int unsigned             tolerance;
      lookup_type              expected_lookups [$];
      int unsigned             failures;
      int unsigned             writes;
      int unsigned             searches;
      int unsigned             hits;

      function new();
         entry_count = ENTRY_COUNT_RESET;
         tolerance   = TOLERANCE_RESET;
         failures    = 0;
         writes      = 0;
         searches    = 0;
         hits        = 0;
      endfunction

      function void set_register(logic reg_sel, int unsigned value);
         if (reg_sel == REG_ENTRY_COUNT)
            entry_count = value;
         else
            tolerance = value;
      endfunction

      function bit near(longint pos, longint key);
         longint delta;
         delta = pos - key;
         if (delta < 0)
            delta = -delta;
         return delta * 256 <= longint'(tolerance);
      endfunction

      function lookup_type hit_at(int unsigned idx);
         lookup_type r;
         r.found          = 1'b1;
         r.match_index    = idx[IDX_W-1:0];
         r.match_position = stored_pos[idx];
         return r;
      endfunction

      function lookup_type predict_lookup(logic signed [POS_W-1:0] key_in);
         lookup_type  miss;
         int unsigned cnt, lo, hi, mid, old_lo, old_hi, n;
         longint      key, probe;
         miss = '0;
         cnt  = (entry_count > TBPS_TABLE_DEPTH) ? TBPS_TABLE_DEPTH : entry_count;
         key  = key_in;
         if (cnt == 0)
            return miss;
         if (key <= 0)
            return hit_at(0);
         if (key * 256 >= longint'(tolerance) * longint'(cnt - 1))
            return hit_at(cnt - 1);
         lo  = 0;
         hi  = cnt;
         mid = cnt / 2;
         for (n = 0; lo < hi && !near(stored_pos[mid], key); n++) begin
            probe = stored_pos[mid];
            if (n >= STEP_CAP)
               return miss;
            old_lo = lo;
            old_hi = hi;
            if (key < probe)
               hi = mid;
            else if (key > probe)
               lo = mid;
            mid = (lo + hi) / 2;
            // interval did not shrink: give up
            if (lo == old_lo && hi == old_hi)
               return miss;
         end
         if (near(stored_pos[mid], key))
            return hit_at(mid);
         return miss;
      endfunction

      function void note_item(logic act, logic [IDX_W-1:0] idx,
                              logic signed [POS_W-1:0] pos, logic signed [POS_W-1:0] key);
         lookup_type r;
         if (act == ACT_WRITE) begin
            stored_pos[idx] = pos;
            writes++;
            expected_lookups.push_back('0);
         end else begin
            r = predict_lookup(key);
            searches++;
            if (r.found)
               hits++;
            expected_lookups.push_back(r);
         end
      endfunction

      function void check_result(logic found, logic [IDX_W-1:0] idx,
                                 logic signed [POS_W-1:0] pos);
         lookup_type want;
         if (expected_lookups.size() == 0) begin
            $error("result transfer with no lookup pending");
            failures++;
            return;
         end
         want = expected_lookups.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            failures++;
         end
         if (idx !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index, idx);
            failures++;
         end
         if (pos !== want.match_position) begin
            $error("match_position: expected %0d, got %0d", want.match_position, pos);
            failures++;
         end
      endfunction
   endclass

   // Every block input starts at a known value; reset is high from time zero
   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_action         = ACT_WRITE;
   logic [IDX_W-1:0]        req_entry_index    = '0;
   logic signed [POS_W-1:0] req_entry_position = '0;
   logic signed [POS_W-1:0] req_search_key     = '0;
   logic                    rsp_stall          = 1'b0;
   logic                    psel               = 1'b0;
   logic                    penable            = 1'b0;
   logic                    pwrite             = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr              = '0;
   logic [CSR_DATA_W-1:0]   pwdata             = '0;
   logic                    req_stall;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [IDX_W-1:0]        rsp_match_index;
   logic signed [POS_W-1:0] rsp_match_position;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   lookup_scoreboard sb;
   int unsigned      gap_pct      = 0;
   int unsigned      stall_pct    = 0;
   int unsigned      cycles       = 0;
   int unsigned      settings     = 0;
   int unsigned      layout_gap   = 1;

   tolerant_binary_position_search uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_entry_index    (req_entry_index),
      .req_entry_position (req_entry_position),
      .req_search_key     (req_search_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_match_index    (rsp_match_index),
      .rsp_match_position (rsp_match_position),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result side: check each transfer, then roll the stall for the next cycle.
   // Both read the pre-edge stall, so the accept decision matches the block's.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_found, rsp_match_index, rsp_match_position);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Pick one of the four idling patterns
   task automatic set_idle(input int unsigned mode);
      case (mode % 4)
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 71; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 71; end
         default: begin gap_pct = 16; stall_pct = 16; end
      endcase
   endtask

   // Present one item, hold it through stalls, record it on transfer.
   // Valid stays high on return so back-to-back items need no second assignment.
   task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                            input logic signed [POS_W-1:0] pos,
                            input logic signed [POS_W-1:0] key);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= act;
      req_entry_index    <= idx;
      req_entry_position <= pos;
      req_search_key     <= key;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_item(act, idx, pos, key);
   endtask

   task automatic write_entry(input logic [IDX_W-1:0] idx, input logic signed [POS_W-1:0] pos);
      send_item(ACT_WRITE, idx, pos, POS_W'($urandom));
   endtask

   // Unused index and position fields get random values too
   task automatic search_for(input logic signed [POS_W-1:0] key);
      send_item(ACT_SEARCH, IDX_W'($urandom), POS_W'($urandom), key);
   endtask

   // Drop valid and wait for every outstanding answer; every item answers once
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_lookups.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register write (setup + access), then read it back over the same port
   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      sb.set_register(reg_sel, value);
      settings++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (prdata !== value) begin
         $error("register %0d readback: expected %0d, got %0d", reg_sel, value, prdata);
         sb.failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Load entries [0, n) with an ascending ramp: spacing gap plus a little jitter
   task automatic load_ramp(input int unsigned n, input int unsigned gap);
      longint      base, top;
      int unsigned i;
      top = 32767 - longint'(n) * gap;
      if ($urandom_range(1) && top >= gap)
         base = $urandom_range(gap);
      else
         base = -32768 + longint'($urandom_range(top + 32768));
      for (i = 0; i < n; i++) begin
         if (n == RAMP_ENTRIES && i % 64 == 0)
            set_idle(i / 64);
         write_entry(i[IDX_W-1:0],
                     POS_W'(base + longint'(i) * gap + $urandom_range(gap / 2)));
      end
      layout_gap = gap;
   endtask

   // Search key mix: mostly near a stored entry, plus the clamp edges and noise
   function automatic logic signed [POS_W-1:0] pick_key(input int unsigned n);
      int unsigned roll, j, t;
      longint      k;
      roll = $urandom_range(99);
      t    = sb.tolerance >> 8;
      if (roll < 8)
         k = -longint'($urandom_range(32768));
      else if (roll < 18)
         k = (longint'(sb.tolerance) * (n - 1) + 255) / 256 - 1 + $urandom_range(2);
      else if (roll < 30)
         k = $urandom;
      else begin
         // near entries that hold written data only
         j = $urandom_range(((n < RAMP_ENTRIES) ? n : RAMP_ENTRIES) - 1);
         k = longint'(sb.stored_pos[j]) + longint'($urandom_range(2 * t + 2)) - (t + 1);
      end
      return k[POS_W-1:0];
   endfunction

   initial begin
      int unsigned p, k, n, m, j, cnt, tol;
      longint      pos;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Empty table after reset: every search misses
      search_for(16'sd100);
      search_for(-16'sd1);
      settle();
      csr_write(REG_ENTRY_COUNT, 8);
      csr_write(REG_TOLERANCE, 1024);
      // Sorted table with the position extremes at both ends
      write_entry(10'd0, 16'sh8000);
      for (j = 1; j < 7; j++)
         write_entry(j[IDX_W-1:0], POS_W'(4 * j));
      write_entry(10'd7, 16'sh7fff);
      search_for(16'sd0);        // zero key clamps to entry 0
      search_for(16'sh8000);     // most negative key
      search_for(16'sh7fff);     // far beyond the last spacing
      search_for(16'sd28);       // exactly on the upper clamp
      search_for(16'sd27);       // matches entry 6 after narrowing
      search_for(16'sd16);       // first probe matches
      search_for(16'sd10);       // match after narrowing
      settle();
      csr_write(REG_TOLERANCE, 256);
      search_for(16'sd5);        // distance equals tolerance
      search_for(16'sd6);        // interval stops shrinking
      write_entry(10'd3, -16'sd100);  // break the ordering
      search_for(16'sd2);
      settle();
      csr_write(REG_TOLERANCE, 0);
      search_for(16'sd1);        // zero tolerance: any positive key clamps high
      settle();
      csr_write(REG_TOLERANCE, 65535);
      search_for(16'sd20);
      settle();
      csr_write(REG_ENTRY_COUNT, 1);
      search_for(16'sd9);        // single entry: both clamps land on entry 0
      settle();

      // ---- ramp over the low entries, plus the last entry for saturated counts ----
      load_ramp(RAMP_ENTRIES, $urandom_range(1, 58));
      write_entry(IDX_W'(TBPS_TABLE_DEPTH - 1), 16'sh7fff);
      settle();

      // ---- random phases: each with its own count, tolerance and idling ----
      for (p = 0; p < PHASES; p++) begin
         set_idle(p);
         if (p == 0)
            cnt = RAMP_ENTRIES;
         else if (p == 1)
            cnt = 2047;          // saturates at the table depth
         else if ($urandom_range(3) == 0)
            cnt = $urandom_range(1, RAMP_ENTRIES);
         else begin
            cnt = $urandom_range(1, 64);
            load_ramp(cnt, $urandom_range(1, 200));
            settle();
         end
         if (cnt >= TBPS_TABLE_DEPTH)
            tol = 0;             // every key clamps: only the first and last entries are read
         else begin
            case ($urandom_range(9))
               0: tol = 0;
               1: tol = 65535;
               2: tol = $urandom_range(65535);
               default: tol = $urandom_range(layout_gap * 128,
                                             (layout_gap * 256 > 65535) ? 65535
                                                                        : layout_gap * 256);
            endcase
         end
         csr_write(REG_ENTRY_COUNT, cnt);
         csr_write(REG_TOLERANCE, tol);
         n = (cnt > TBPS_TABLE_DEPTH) ? TBPS_TABLE_DEPTH : cnt;
         m = (n < RAMP_ENTRIES) ? n : RAMP_ENTRIES;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 15) begin
               // Rewrite an entry: half keep the order, half are noise
               j = $urandom_range(m - 1);
               if ($urandom_range(1) && j > 0 && j + 1 < m)
                  pos = (longint'(sb.stored_pos[j - 1]) + sb.stored_pos[j + 1]) / 2;
               else
                  pos = $urandom;
               write_entry(j[IDX_W-1:0], pos[POS_W-1:0]);
            end else begin
               search_for(pick_key(n));
            end
         end
         settle();
      end

      // Drain, then give any stray transfer time to show up
      settle();
      repeat (20) @(posedge clock);
      $display("Covered %0d table writes and %0d searches (%0d matched, %0d missed)",
               sb.writes, sb.searches, sb.hits, sb.searches - sb.hits);
      $display("across %0d register writes, from an empty table to a saturated count",
               settings);
      if (sb.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
